FILE: rtl/bsfr_pkg.sv
// Shared types and constants of the byte-stuffed frame receiver.
package bsfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 12;
  localparam int MAX_CONTENT = 2048;
  localparam int MIN_CONTENT = 3;
  localparam int CNT_W       = $clog2(MAX_CONTENT + 1);
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FLAG   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = CFG_IDX_W'(2);

  localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;
  localparam logic [BYTE_W-1:0] MASK_RESET   = 8'd32;

  typedef enum logic [2:0] {
    K_PAYLOAD  = 3'd0,
    K_GOOD     = 3'd1,
    K_BADSUM   = 3'd2,
    K_SHORT    = 3'd3,
    K_BADESC   = 3'd4,
    K_OVERFLOW = 3'd5
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              block_start;
  } in_word_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  frame_length;
  } out_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_value;
    logic [BYTE_W-1:0] escape_value;
    logic [BYTE_W-1:0] xor_mask;
  } cfg_t;

endpackage

FILE: rtl/bsfr_deframe.sv
// Framing state and per-byte destuffing, checksum and status logic.
module bsfr_deframe (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  bsfr_pkg::cfg_t     cfg,
  input  bsfr_pkg::in_word_t word,
  output logic               has_result,
  output bsfr_pkg::out_word_t result
);
  import bsfr_pkg::*;

  logic              in_frame, in_frame_next;
  logic              escape_pending, escape_pending_next;
  logic              held_valid, held_valid_next;
  logic [BYTE_W-1:0] held_byte, held_byte_next;
  logic [BYTE_W-1:0] sum_emitted, sum_emitted_next;
  logic [CNT_W-1:0]  content_count, content_count_next;

  always_comb begin
    logic              cur_frame;
    logic              cur_esc;
    logic              cur_hv;
    logic [BYTE_W-1:0] cur_held;
    logic [BYTE_W-1:0] cur_sum;
    logic [CNT_W-1:0]  cur_cnt;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
    logic              take;
    logic              bad_esc;

    // A block start wipes the framing state before the byte is looked at.
    cur_frame = in_frame & ~word.block_start;
    cur_esc   = escape_pending & ~word.block_start;
    cur_hv    = held_valid & ~word.block_start;
    cur_held  = word.block_start ? '0 : held_byte;
    cur_sum   = word.block_start ? '0 : sum_emitted;
    cur_cnt   = word.block_start ? '0 : content_count;
    b         = word.rx_byte;
    c         = b;
    take      = 1'b0;
    bad_esc   = 1'b0;

    in_frame_next       = cur_frame;
    escape_pending_next = cur_esc;
    held_valid_next     = cur_hv;
    held_byte_next      = cur_held;
    sum_emitted_next    = cur_sum;
    content_count_next  = cur_cnt;

    has_result          = 1'b0;
    result.kind         = K_PAYLOAD;
    result.payload_byte = '0;
    result.frame_length = '0;

    if (cur_esc) begin
      escape_pending_next = 1'b0;
      if (b == (cfg.escape_value ^ cfg.xor_mask)) begin
        c    = cfg.escape_value;
        take = cur_frame;
      end else if (b == (cfg.flag_value ^ cfg.xor_mask)) begin
        c    = cfg.flag_value;
        take = cur_frame;
      end else begin
        bad_esc = 1'b1;
      end
    end else if (b == cfg.flag_value) begin
      if (cur_frame) begin
        has_result          = 1'b1;
        result.frame_length = LEN_W'(cur_cnt);
        if (cur_cnt >= CNT_W'(MIN_CONTENT) && cur_hv) begin
          result.kind         = (cur_sum == cur_held) ? K_GOOD : K_BADSUM;
          result.frame_length = LEN_W'(cur_cnt - CNT_W'(1));
        end else begin
          result.kind = K_SHORT;
        end
        in_frame_next = 1'b0;
      end else begin
        in_frame_next = 1'b1;
      end
      escape_pending_next = 1'b0;
      held_valid_next     = 1'b0;
      held_byte_next      = '0;
      sum_emitted_next    = '0;
      content_count_next  = '0;
    end else if (b == cfg.escape_value) begin
      escape_pending_next = cur_frame;
    end else begin
      take = cur_frame;
    end

    if (take) begin
      if (cur_cnt >= CNT_W'(MAX_CONTENT)) begin
        // Frame is full: drop the byte and abort.
        has_result          = 1'b1;
        result.kind         = K_OVERFLOW;
        result.frame_length = LEN_W'(cur_cnt);
        in_frame_next       = 1'b0;
        escape_pending_next = 1'b0;
        held_valid_next     = 1'b0;
      end else begin
        content_count_next = cur_cnt + CNT_W'(1);
        if (cur_hv) begin
          has_result          = 1'b1;
          result.payload_byte = cur_held;
          sum_emitted_next    = cur_sum + cur_held;
        end
        held_byte_next  = c;
        held_valid_next = 1'b1;
      end
    end

    if (bad_esc) begin
      has_result          = 1'b1;
      result.kind         = K_BADESC;
      result.frame_length = LEN_W'(cur_cnt);
      in_frame_next       = 1'b0;
      escape_pending_next = 1'b0;
      held_valid_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      held_valid     <= 1'b0;
      held_byte      <= '0;
      sum_emitted    <= '0;
      content_count  <= '0;
    end else if (step) begin
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      held_valid     <= held_valid_next;
      held_byte      <= held_byte_next;
      sum_emitted    <= sum_emitted_next;
      content_count  <= content_count_next;
    end
  end

  a_esc_in_frame: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> in_frame)
    else $error("escape pending outside a frame");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    content_count <= CNT_W'(MAX_CONTENT))
    else $error("content count beyond frame limit");

  a_held_counted: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (content_count != '0))
    else $error("held byte without any counted content");

endmodule

FILE: rtl/byte_stuffed_frame_receiver_unit.sv
// Top level of the byte-stuffed frame receiver: word registers and configuration.
//
//  channel   direction  handshake                      word
//  byte      in         byte_valid / byte_stall        byte_word (rx_byte, block_start)
//  result    out        result_valid / result_stall    result_word (kind, payload_byte,
//                                                      frame_length)
//  config    in         cfg_write_en                   cfg_index, cfg_data
//
// A line word is held in the input register; its result is then loaded into the
// result register, which offers it on result_valid. One word is accepted every
// cycle while the result side keeps up.
// Payload bytes come out one word late, as the last content byte of a frame is its
// checksum and is held back. A word that yields no result still passes the core.
// Reset (rst, synchronous) empties both registers, clears the framing state and
// loads the default flag, escape and mask values; there is no clearing pass.
// A stall on the result side holds a valid result in the result register and, once the input
// register is full as well, raises byte_stall in the same cycle.
module byte_stuffed_frame_receiver_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  output logic                            byte_stall,
  input  bsfr_pkg::in_word_t              byte_word,
  output logic                            result_valid,
  input  logic                            result_stall,
  output bsfr_pkg::out_word_t             result_word,
  input  logic                            cfg_write_en,
  input  logic [bsfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsfr_pkg::BYTE_W-1:0]     cfg_data
);
  import bsfr_pkg::*;

  cfg_t      cfg;
  in_word_t  held_word;
  logic      in_full;
  logic      advance;
  logic      step;
  logic      has_result;
  out_word_t core_result;

  // Configuration registers; writes to an unused index are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_value   <= FLAG_RESET;
      cfg.escape_value <= ESCAPE_RESET;
      cfg.xor_mask     <= MASK_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FLAG:   cfg.flag_value   <= cfg_data;
        REG_ESCAPE: cfg.escape_value <= cfg_data;
        REG_MASK:   cfg.xor_mask     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register can take a new value when it is empty or being drained.
  assign advance    = !result_valid || !result_stall;
  assign step       = in_full && advance;
  assign byte_stall = in_full && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      held_word <= byte_word;
    end
  end

  bsfr_deframe u_deframe (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .cfg        (cfg),
    .word       (held_word),
    .has_result (has_result),
    .result     (core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      result_word <= core_result;
    end
  end

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    (in_full && result_valid && result_stall) |-> byte_stall)
    else $error("input accepted while both registers are blocked");

  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(step))
    else $error("result appeared without a core step");

  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result_word.kind == K_PAYLOAD) ? (result_word.frame_length == '0)
                                                      : (result_word.payload_byte == '0)))
    else $error("result word carries a field that its kind leaves at zero");

endmodule
